[rtl/ppmd_pkg.sv]
// shared constants for the point to polyline distance unit
package ppmd_pkg;

	localparam int COORD_BITS_DEF      = 24;
	localparam int ALPHA_FRAC_BITS_DEF = 16;
	localparam int SQ_BITS             = 50;
	localparam int DIST_BITS           = 25;

	localparam logic [SQ_BITS-1:0]   SQ_MAX   = {SQ_BITS{1'b1}};
	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

endpackage

[rtl/ppmd_mul.sv]
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
module ppmd_mul #(
	parameter int MW = 25
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MW-1:0]   a,
	input  logic [MW-1:0]   b,
	output logic            done,
	output logic [2*MW-1:0] prod
);

	localparam int PW = 2 * MW;
	localparam int CW = $clog2(MW);

	logic [PW-1:0] a_q;
	logic [MW-1:0] b_q;
	logic [PW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload path
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PW'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (b_q[0] ? a_q : '0);
			a_q   <= a_q << 1;
			b_q   <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

[rtl/ppmd_sqrt.sv]
// digit-by-digit integer square root, one result bit per cycle
module ppmd_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppmd_pkg::SQ_BITS-1:0]  value,
	output logic                          done,
	output logic [ppmd_pkg::DIST_BITS-1:0] root
);

	localparam int RB = ppmd_pkg::DIST_BITS;
	localparam int VB = ppmd_pkg::SQ_BITS;
	localparam int RW = RB + 3;
	localparam int CW = $clog2(RB);

	logic [VB-1:0] val_q;
	logic [RW-1:0] rem_q;
	logic [RB-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [RW-1:0] rem_next;
	logic [RW-1:0] trial;

	assign rem_next = {rem_q[RW-3:0], val_q[VB-1 -: 2]};
	assign trial    = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(RB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= val_q << 2;
			if (rem_next >= trial) begin
				rem_q  <= rem_next - trial;
				root_q <= {root_q[RB-2:0], 1'b1};
			end else begin
				rem_q  <= rem_next;
				root_q <= {root_q[RB-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[rtl/point_polyline_min_distance_unit.sv]
// top level: minimum distance from a query point to a stream of polyline vertices
// a vertex that closes no segment goes straight to S_END; one that closes a segment runs its
//   products, MW = max(COORD_BITS, ALPHA_FRAC_BITS) + 1 bits wide, through the one
//   bit-serial multiplier that all eight products share
// a last vertex also runs the bit-serial square root, unless the query had no segment
// throughput: one vertex at a time, accepted only while the sequencer is idle
// reset: arst_n clears the sequencer, stored vertex and flags, and sets the minimum to all ones
module point_polyline_min_distance_unit #(
	parameter int COORD_BITS      = ppmd_pkg::COORD_BITS_DEF,
	parameter int ALPHA_FRAC_BITS = ppmd_pkg::ALPHA_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            vertex_valid,
	output logic                            vertex_ready,
	input  logic signed [COORD_BITS-1:0]    query_x,
	input  logic signed [COORD_BITS-1:0]    query_y,
	input  logic signed [COORD_BITS-1:0]    vertex_x,
	input  logic signed [COORD_BITS-1:0]    vertex_y,
	input  logic                            starts_polyline,
	input  logic                            last_vertex,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [ppmd_pkg::DIST_BITS-1:0]  distance,
	output logic                            found
);

	localparam int C   = COORD_BITS;
	localparam int F   = ALPHA_FRAC_BITS;
	localparam int D   = C + 1;              // coordinate difference, signed
	localparam int EW  = C + 2;              // error after projection, signed
	localparam int MW  = (C + 1 > F + 1) ? C + 1 : F + 1;
	localparam int PW  = 2 * MW;             // multiplier product
	localparam int SB  = ppmd_pkg::SQ_BITS;
	localparam int SW  = (PW + 1 > SB) ? PW + 1 : SB;
	localparam int FCW = $clog2(F);

	typedef enum logic [3:0] {
		S_IDLE, S_LEN_X, S_LEN_Y, S_DOT_X, S_DOT_Y, S_ALPHA, S_DIV,
		S_OFF_X, S_OFF_Y, S_SQ_X, S_SQ_Y, S_CMP, S_END, S_SQRT, S_PUT
	} state_t;

	state_t state_q;

	// running state
	logic [C-1:0]  prev_x_q, prev_y_q;
	logic          have_prev_q, any_q, last_q;
	logic [SB-1:0] best_q;

	// segment working registers
	logic [D-1:0]    apx_q, apy_q, abx_q, aby_q;
	logic [PW:0]     len2_q;
	logic [PW+1:0]   dot_q;
	logic [PW:0]     rem_q;
	logic [F:0]      alpha_q;
	logic [FCW-1:0]  div_cnt_q;
	logic [EW-1:0]   ex_q, ey_q;
	logic [PW:0]     sum_q;
	logic            issued_q;

	// output register
	logic                          out_valid_q;
	logic [ppmd_pkg::DIST_BITS-1:0] dist_q, res_dist_q;
	logic                          found_q, res_found_q;

	// magnitudes of the working values
	logic [D-1:0]  apx_m, apy_m, abx_m, aby_m;
	logic [EW-1:0] ex_m, ey_m;

	assign apx_m = apx_q[D-1] ? (~apx_q + 1'b1) : apx_q;
	assign apy_m = apy_q[D-1] ? (~apy_q + 1'b1) : apy_q;
	assign abx_m = abx_q[D-1] ? (~abx_q + 1'b1) : abx_q;
	assign aby_m = aby_q[D-1] ? (~aby_q + 1'b1) : aby_q;
	assign ex_m  = ex_q[EW-1] ? (~ex_q + 1'b1) : ex_q;
	assign ey_m  = ey_q[EW-1] ? (~ey_q + 1'b1) : ey_q;

	// shared multiplier
	logic          mul_state, mul_start, mul_done;
	logic [MW-1:0] mul_a, mul_b;
	logic [PW-1:0] mul_prod;

	always_comb begin
		mul_state = 1'b1;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			S_LEN_X: begin mul_a = MW'(abx_m); mul_b = MW'(abx_m); end
			S_LEN_Y: begin mul_a = MW'(aby_m); mul_b = MW'(aby_m); end
			S_DOT_X: begin mul_a = MW'(apx_m); mul_b = MW'(abx_m); end
			S_DOT_Y: begin mul_a = MW'(apy_m); mul_b = MW'(aby_m); end
			S_OFF_X: begin mul_a = MW'(abx_m); mul_b = MW'(alpha_q); end
			S_OFF_Y: begin mul_a = MW'(aby_m); mul_b = MW'(alpha_q); end
			S_SQ_X:  begin mul_a = MW'(ex_m);  mul_b = MW'(ex_m);  end
			S_SQ_Y:  begin mul_a = MW'(ey_m);  mul_b = MW'(ey_m);  end
			default: mul_state = 1'b0;
		endcase
	end

	assign mul_start = mul_state && !issued_q;

	ppmd_mul #(.MW(MW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// square root for the query result
	logic                          sqrt_start, sqrt_done;
	logic [ppmd_pkg::DIST_BITS-1:0] sqrt_root;

	assign sqrt_start = (state_q == S_END) && last_q && any_q;

	ppmd_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (best_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// signed product, dot step and projected offset
	logic          prod_neg;
	logic [PW+1:0] prod_dot;
	logic [PW:0]   prod_off, off_sum, off_sh;
	logic [EW-1:0] off_e;
	logic [PW+1:0] r2;
	logic [SW-1:0] sum_w, sat_w;

	always_comb begin
		prod_neg = (state_q == S_DOT_X) ? (apx_q[D-1] ^ abx_q[D-1]) :
		           (state_q == S_DOT_Y) ? (apy_q[D-1] ^ aby_q[D-1]) :
		           (state_q == S_OFF_X) ? abx_q[D-1] : aby_q[D-1];
		prod_dot = prod_neg ? (~(PW+2)'(mul_prod) + 1'b1) : (PW+2)'(mul_prod);
		prod_off = prod_neg ? (~(PW+1)'(mul_prod) + 1'b1) : (PW+1)'(mul_prod);
		// round to nearest, ties upward, then floor shift
		off_sum  = prod_off + ((PW+1)'(1) << (F - 1));
		off_sh   = $unsigned($signed(off_sum) >>> F);
		off_e    = off_sh[EW-1:0];
		r2       = {rem_q, 1'b0};
		sum_w    = SW'(sum_q);
		sat_w    = (sum_w > SW'(ppmd_pkg::SQ_MAX)) ? SW'(ppmd_pkg::SQ_MAX) : sum_w;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
			any_q       <= 1'b0;
			last_q      <= 1'b0;
			best_q      <= ppmd_pkg::SQ_MAX;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a taken beat clears valid unless the next result loads in the same cycle
			if (out_valid_q && result_ready && state_q != S_PUT) begin
				out_valid_q <= 1'b0;
			end
			if (mul_state) begin
				if (!issued_q) begin
					issued_q <= 1'b1;
				end else if (mul_done) begin
					issued_q <= 1'b0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (vertex_valid) begin
						prev_x_q    <= vertex_x;
						prev_y_q    <= vertex_y;
						have_prev_q <= 1'b1;
						last_q      <= last_vertex;
						if (have_prev_q && !starts_polyline) begin
							any_q   <= 1'b1;
							state_q <= S_LEN_X;
						end else begin
							state_q <= S_END;
						end
					end
				end
				S_LEN_X: if (issued_q && mul_done) state_q <= S_LEN_Y;
				S_LEN_Y: if (issued_q && mul_done) state_q <= S_DOT_X;
				S_DOT_X: if (issued_q && mul_done) state_q <= S_DOT_Y;
				S_DOT_Y: if (issued_q && mul_done) state_q <= S_ALPHA;
				S_ALPHA: begin
					if (len2_q == '0) begin
						state_q <= S_SQ_X;
					end else if (dot_q[PW+1] || dot_q == '0 ||
					             dot_q >= (PW+2)'(len2_q)) begin
						state_q <= S_OFF_X;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV:   if (div_cnt_q == FCW'(F - 1)) state_q <= S_OFF_X;
				S_OFF_X: if (issued_q && mul_done) state_q <= S_OFF_Y;
				S_OFF_Y: if (issued_q && mul_done) state_q <= S_SQ_X;
				S_SQ_X:  if (issued_q && mul_done) state_q <= S_SQ_Y;
				S_SQ_Y:  if (issued_q && mul_done) state_q <= S_CMP;
				S_CMP: begin
					if (sat_w < SW'(best_q)) begin
						best_q <= sat_w[SB-1:0];
					end
					state_q <= S_END;
				end
				S_END: begin
					if (last_q) begin
						// query ends: clear running state, the root unit holds the minimum
						prev_x_q    <= '0;
						prev_y_q    <= '0;
						have_prev_q <= 1'b0;
						any_q       <= 1'b0;
						best_q      <= ppmd_pkg::SQ_MAX;
						state_q     <= any_q ? S_SQRT : S_PUT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SQRT:  if (sqrt_done) state_q <= S_PUT;
				S_PUT: begin
					if (!out_valid_q || result_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				apx_q <= D'({query_x[C-1], query_x} - {prev_x_q[C-1], prev_x_q});
				apy_q <= D'({query_y[C-1], query_y} - {prev_y_q[C-1], prev_y_q});
				abx_q <= D'({vertex_x[C-1], vertex_x} - {prev_x_q[C-1], prev_x_q});
				aby_q <= D'({vertex_y[C-1], vertex_y} - {prev_y_q[C-1], prev_y_q});
			end
			S_LEN_X: if (issued_q && mul_done) len2_q <= (PW+1)'(mul_prod);
			S_LEN_Y: if (issued_q && mul_done) len2_q <= len2_q + (PW+1)'(mul_prod);
			S_DOT_X: if (issued_q && mul_done) dot_q <= prod_dot;
			S_DOT_Y: if (issued_q && mul_done) dot_q <= dot_q + prod_dot;
			S_ALPHA: begin
				ex_q      <= {apx_q[D-1], apx_q};
				ey_q      <= {apy_q[D-1], apy_q};
				rem_q     <= dot_q[PW:0];
				div_cnt_q <= '0;
				// clamp to one only for a positive dot at or past the segment end
				if (!dot_q[PW+1] && dot_q != '0 && dot_q >= (PW+2)'(len2_q)) begin
					alpha_q <= (F+1)'(1) << F;
				end else begin
					alpha_q <= '0;
				end
			end
			S_DIV: begin
				// restoring division, one quotient bit a cycle
				div_cnt_q <= div_cnt_q + 1'b1;
				if (r2 >= (PW+2)'(len2_q)) begin
					rem_q   <= (PW+1)'(r2 - (PW+2)'(len2_q));
					alpha_q <= {alpha_q[F-1:0], 1'b1};
				end else begin
					rem_q   <= r2[PW:0];
					alpha_q <= {alpha_q[F-1:0], 1'b0};
				end
			end
			S_OFF_X: if (issued_q && mul_done) ex_q <= {apx_q[D-1], apx_q} - off_e;
			S_OFF_Y: if (issued_q && mul_done) ey_q <= {apy_q[D-1], apy_q} - off_e;
			S_SQ_X:  if (issued_q && mul_done) sum_q <= (PW+1)'(mul_prod);
			S_SQ_Y:  if (issued_q && mul_done) sum_q <= sum_q + (PW+1)'(mul_prod);
			S_END: begin
				res_dist_q  <= ppmd_pkg::DIST_MAX;
				res_found_q <= 1'b0;
			end
			S_SQRT: begin
				if (sqrt_done) begin
					res_dist_q  <= sqrt_root;
					res_found_q <= 1'b1;
				end
			end
			S_PUT: begin
				if (!out_valid_q || result_ready) begin
					dist_q  <= res_dist_q;
					found_q <= res_found_q;
				end
			end
			default: ;
		endcase
	end

	assign vertex_ready = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign distance     = dist_q;
	assign found        = found_q;

endmodule

[rtl/ppmd_checker.sv]
// port-level checks for the point to polyline distance unit, with bind
module ppmd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           vertex_valid,
	input logic                           vertex_ready,
	input logic                           last_vertex,
	input logic                           result_valid,
	input logic                           result_ready,
	input logic [ppmd_pkg::DIST_BITS-1:0] distance,
	input logic                           found
);

	// a result with no segment carries the saturated distance
	a_no_seg_max: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !found) |-> (distance == ppmd_pkg::DIST_MAX))
		else $error("no-segment result without saturated distance");

	// the sequencer leaves idle after every accepted beat
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(vertex_valid && vertex_ready) |=> !vertex_ready)
		else $error("ready held after accepted vertex beat");

	// a vertex that is not last never produces a result beat next cycle
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(vertex_valid && vertex_ready && !last_vertex && !result_valid) |=>
		!result_valid)
		else $error("result beat without last vertex");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=>
		(result_valid && $stable(distance) && $stable(found)))
		else $error("stalled result beat changed");

endmodule

bind point_polyline_min_distance_unit ppmd_checker u_ppmd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.vertex_valid (vertex_valid),
	.vertex_ready (vertex_ready),
	.last_vertex  (last_vertex),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.distance     (distance),
	.found        (found)
);

[test/tb_top.sv]
// testbench for the point to polyline minimum distance unit
module tb_top;

	localparam int CW = 24;
	localparam int AF = 16;
	localparam int STALL_LIMIT = 200000;

	// predicted result of one query, oldest first in the scoreboard
	typedef struct packed {
		logic [ppmd_pkg::DIST_BITS-1:0] dist_val;
		logic                           hit;
	} query_result_t;

	// running state of the polyline walk, mirrors the block
	class distance_scoreboard;
		logic signed [63:0] last_x, last_y;
		bit                 have_last;
		logic [63:0]        min_sq;
		bit                 saw_segment;
		query_result_t      pending[$];
		int                 errors;

		function new();
			errors = 0;
			clear_walk();
		endfunction

		function void clear_walk();
			last_x = 0;
			last_y = 0;
			have_last = 0;
			min_sq = {14'd0, ppmd_pkg::SQ_MAX};
			saw_segment = 0;
		endfunction

		function logic [63:0] magnitude(logic [63:0] v);
			return v[63] ? (64'd0 - v) : v;
		endfunction

		function logic [63:0] floor_sqrt(logic [63:0] v);
			logic [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// squared distance, integer (q.0), from the query to segment a-b, saturated at SQ_MAX
		function logic [63:0] segment_sq(logic [63:0] qx, qy, ax, ay, bx, by);
			logic [63:0] apx, apy, abx, aby, len2, dotp, alpha, rem, ex, ey;
			logic [63:0] offx, offy, sum;
			apx = qx - ax; apy = qy - ay;
			abx = bx - ax; aby = by - ay;
			len2 = magnitude(abx) * magnitude(abx) + magnitude(aby) * magnitude(aby);
			ex = apx; ey = apy;
			if (len2 != 0) begin
				dotp = apx * abx + apy * aby;
				if (dotp[63] || dotp == 0) alpha = 0;
				else if (dotp >= len2) alpha = 64'd1 << AF;
				else begin
					// restoring division, truncated fraction
					rem = dotp;
					alpha = 0;
					for (int i = 0; i < AF; i++) begin
						rem = rem << 1;
						alpha = alpha << 1;
						if (rem >= len2) begin
							rem = rem - len2;
							alpha[0] = 1'b1;
						end
					end
				end
				// round half up, then floor shift
				offx = $signed(abx * alpha + (64'd1 << (AF - 1))) >>> AF;
				offy = $signed(aby * alpha + (64'd1 << (AF - 1))) >>> AF;
				ex = apx - offx;
				ey = apy - offy;
			end
			sum = magnitude(ex) * magnitude(ex) + magnitude(ey) * magnitude(ey);
			return (sum > {14'd0, ppmd_pkg::SQ_MAX}) ? {14'd0, ppmd_pkg::SQ_MAX} : sum;
		endfunction

		function void note_vertex(logic signed [CW-1:0] qx, qy, vx, vy, bit starts, bit fin);
			logic [63:0] d2;
			query_result_t r;
			if (have_last && !starts) begin
				d2 = segment_sq(64'(qx), 64'(qy), last_x, last_y, 64'(vx), 64'(vy));
				if (d2 < min_sq) min_sq = d2;
				saw_segment = 1;
			end
			last_x = 64'(vx);
			last_y = 64'(vy);
			have_last = 1;
			if (fin) begin
				if (saw_segment) begin
					r.dist_val = ppmd_pkg::DIST_BITS'(floor_sqrt(min_sq));
					r.hit = 1;
				end else begin
					r.dist_val = ppmd_pkg::DIST_MAX;
					r.hit = 0;
				end
				pending.push_back(r);
				clear_walk();
			end
		endfunction

		function void check_result(logic [ppmd_pkg::DIST_BITS-1:0] d, logic f);
			query_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result distance %0d found %0b", $time, d, f);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d !== e.dist_val) begin
				$display("%0t: distance expected %0d actual %0d", $time, e.dist_val, d);
				errors++;
			end
			if (f !== e.hit) begin
				$display("%0t: found expected %0b actual %0b", $time, e.hit, f);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 0;
	logic                           arst_n = 0;
	logic                           vertex_valid = 0;
	logic                           vertex_ready;
	logic signed [CW-1:0]           query_x = 0, query_y = 0, vertex_x = 0, vertex_y = 0;
	logic                           starts_polyline = 0, last_vertex = 0;
	logic                           result_valid;
	logic                           result_ready = 0;
	logic [ppmd_pkg::DIST_BITS-1:0] distance;
	logic                           found;

	distance_scoreboard sb = new();
	int send_idle_pct = 15;
	int recv_idle_pct = 65;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	point_polyline_min_distance_unit #(.COORD_BITS(CW), .ALPHA_FRAC_BITS(AF)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.vertex_valid(vertex_valid), .vertex_ready(vertex_ready),
		.query_x(query_x), .query_y(query_y),
		.vertex_x(vertex_x), .vertex_y(vertex_y),
		.starts_polyline(starts_polyline), .last_vertex(last_vertex),
		.result_valid(result_valid), .result_ready(result_ready),
		.distance(distance), .found(found)
	);

	// result side: check at the rising edge, pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) sb.check_result(distance, found);
	end
	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog: cycles with no beat on either side
	always @(posedge clk) begin
		if ((vertex_valid && vertex_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// one input beat, with random idle cycles ahead of it; returns at a falling edge
	task automatic send_vertex(logic signed [CW-1:0] qx, qy, vx, vy, bit starts, bit fin);
		while ($urandom_range(99) < send_idle_pct) begin
			vertex_valid <= 0;
			@(negedge clk);
		end
		vertex_valid <= 1;
		query_x <= qx; query_y <= qy;
		vertex_x <= vx; vertex_y <= vy;
		starts_polyline <= starts; last_vertex <= fin;
		@(posedge clk);
		while (!vertex_ready) @(posedge clk);
		sb.note_vertex(qx, qy, vx, vy, starts, fin);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		vertex_valid <= 0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [CW-1:0] rand_coord(int span);
		case ($urandom_range(9))
			0: return CW'($urandom);                    // full range
			1: return ($urandom_range(1) == 1) ? 24'sh7fffff : -24'sh800000;
			default: return CW'(int'($urandom_range(2 * span)) - span);
		endcase
	endfunction

	// a polyline query: mostly well formed, sometimes split or noisy flags
	task automatic random_query(output int n);
		logic signed [CW-1:0] qx, qy, vx, vy;
		int span;
		bit starts;
		span = $urandom_range(3) == 0 ? 4000000 : 2000;
		n = $urandom_range(5) + 1;
		qx = rand_coord(span);
		qy = rand_coord(span);
		vx = rand_coord(span);
		vy = rand_coord(span);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				qx = rand_coord(span);
				qy = rand_coord(span);
			end
			if ($urandom_range(7) != 0) begin
				vx = rand_coord(span);
				vy = rand_coord(span);
			end
			starts = (i == 0) ? ($urandom_range(1) == 1) : ($urandom_range(9) == 0);
			send_vertex(qx, qy, vx, vy, starts, i == n - 1);
		end
	endtask

	initial begin
		int sent;
		int n;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: empty and single-vertex queries
		send_vertex(0, 0, 0, 0, 0, 1);
		send_vertex(16, 16, 100, -100, 1, 1);
		// zero-length segment
		send_vertex(32, 48, 80, 80, 1, 0);
		send_vertex(32, 48, 80, 80, 0, 1);
		// projection inside, behind and beyond the segment
		send_vertex(50, 70, 0, 0, 0, 0);
		send_vertex(50, 70, 160, 0, 0, 1);
		send_vertex(-90, 5, 0, 0, 0, 0);
		send_vertex(-90, 5, 160, 30, 0, 1);
		send_vertex(400, -5, 0, 0, 0, 0);
		send_vertex(400, -5, 160, 30, 0, 1);
		// extremes of the coordinate range
		send_vertex(24'sh7fffff, 24'sh7fffff, -24'sh800000, -24'sh800000, 0, 0);
		send_vertex(24'sh7fffff, 24'sh7fffff, -24'sh800000, 24'sh7fffff, 0, 1);
		send_vertex(-24'sh800000, 24'sh7fffff, 24'sh7fffff, -24'sh800000, 0, 0);
		send_vertex(24'sh7fffff, -24'sh800000, -24'sh800000, 24'sh7fffff, 0, 1);
		// query point moves mid query, and a split polyline
		send_vertex(0, 0, 10, 10, 0, 0);
		send_vertex(5, 5, 30, 10, 0, 0);
		send_vertex(-500, 9, 1000, 2000, 1, 0);
		send_vertex(-500, 9, 1000, 2100, 0, 1);
		// a polyline restart that leaves no segment at all
		send_vertex(1, 1, 7, 7, 0, 0);
		send_vertex(1, 1, 9, 9, 1, 1);

		// hold off until every result is in
		wait_drained();

		sent = 0;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 65 : 0;
			recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 15 : 0;
			while (sent < 560 * (phase + 1)) begin
				random_query(n);
				sent = sent + n;
			end
		end

		wait_drained();
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
